>>> rtl/nmds_pkg.sv
// Shared constants for the neighbour maximum difference scan.
package nmds_pkg;

  // Width of the side length configuration register and its value after reset.
  localparam int unsigned SideBits  = 11;
  localparam int unsigned SideReset = 8;

endpackage

>>> rtl/neighbor_max_difference_scan.sv
// Neighbour maximum difference scan over a square raster image, one pixel per cycle while not stalled.
//
// Pixels of a side_length x side_length image arrive in raster order on the slave stream.
// Each pixel is compared with its left, upper-left, upper and upper-right neighbours.
// The block tracks the largest absolute difference, together with the high and low values
// of the pairs that reach it.
// After the last pixel of a frame, one result request leaves on the master stream. The
// tracking then clears for the next frame.
// A pixel is taken every cycle, unless held back as below. The whole update sits between the
// tracking registers: four subtract/compare paths and a three-level merge.
// The result lands in an output register in the cycle after the last pixel. That register
// frees the input side, so the next frame streams on while the result waits; only the
// last pixel of that next frame is held back until the waiting result has been taken.
// The row above is held in a MAX_SIDE-deep single-port-write memory. It is read one column
// ahead, and a bypass covers the two-column case.
// The row memory needs no clearing.
// Writing cfg_wdata_i restarts the frame. Side length 0 is taken as 1, and values above
// MAX_SIDE are taken as MAX_SIDE.
module neighbor_max_difference_scan
  import nmds_pkg::*;
#(
  parameter int unsigned MAX_SIDE   = 1024,
  parameter int unsigned PIXEL_BITS = 8,
  localparam int unsigned InW  = ((PIXEL_BITS + 7) / 8) * 8,
  localparam int unsigned OutW = ((3 * PIXEL_BITS + 7) / 8) * 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_we_i,
  input  logic [SideBits-1:0] cfg_wdata_i,    // side_length
  // pixel stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InW-1:0]      s_axis_tdata,   // pixel_value
  // result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutW-1:0]     m_axis_tdata    // high_value, low_value, largest_difference
);

  localparam int unsigned ColW = $clog2(MAX_SIDE);
  localparam int unsigned CntW = $clog2(MAX_SIDE + 1);

  typedef struct packed {
    logic [PIXEL_BITS-1:0] diff;
    logic [PIXEL_BITS-1:0] high;
    logic [PIXEL_BITS-1:0] low;
  } cand_t;

  function automatic cand_t make_pair(logic [PIXEL_BITS-1:0] a, logic [PIXEL_BITS-1:0] b);
    cand_t res;
    res.high = (a > b) ? a : b;
    res.low  = (a > b) ? b : a;
    res.diff = res.high - res.low;
    return res;
  endfunction

  // Larger difference wins; on a tie the pair ranges are joined.
  function automatic cand_t merge(cand_t x, cand_t y);
    cand_t res;
    if (x.diff > y.diff) begin
      res = x;
    end else if (y.diff > x.diff) begin
      res = y;
    end else begin
      res.diff = x.diff;
      res.high = (x.high > y.high) ? x.high : y.high;
      res.low  = (x.low < y.low) ? x.low : y.low;
    end
    return res;
  endfunction

  logic [SideBits-1:0]   side_q;
  logic [CntW-1:0]       side_eff;
  logic [ColW-1:0]       col_q, row_q;
  logic [PIXEL_BITS-1:0] left_q, upleft_q, up_q, first_q;
  logic [PIXEL_BITS-1:0] rd_q, fwd_pix_q;
  logic                  fwd_q;
  cand_t                 best_q;
  logic                  out_valid_q;
  cand_t                 out_q;

  logic [PIXEL_BITS-1:0] row_mem [MAX_SIDE];

  logic                  accept;
  logic [PIXEL_BITS-1:0] pix;
  logic [PIXEL_BITS-1:0] upright;
  logic                  last_col, last_row, frame_end;
  logic [ColW-1:0]       col_nxt;
  logic [CntW-1:0]       rd_addr_full;
  logic [ColW-1:0]       rd_addr;
  cand_t                 c_left, c_upleft, c_up, c_upright;
  cand_t                 m_a, m_b, m_all, best_d;

  always_comb begin
    if (side_q == '0) begin
      side_eff = CntW'(1);
    end else if (side_q > MAX_SIDE) begin
      side_eff = CntW'(MAX_SIDE);
    end else begin
      side_eff = CntW'(side_q);
    end
  end

  // only the last pixel of a frame needs the output register free
  assign s_axis_tready = !frame_end || !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign pix           = s_axis_tdata[PIXEL_BITS-1:0];
  assign upright       = fwd_q ? fwd_pix_q : rd_q;

  assign last_col  = (CntW'(col_q) == side_eff - CntW'(1));
  assign last_row  = (CntW'(row_q) == side_eff - CntW'(1));
  assign frame_end = last_col && last_row;
  assign col_nxt   = last_col ? '0 : col_q + ColW'(1);

  // Upper-right neighbour of the next pixel is fetched now.
  assign rd_addr_full = CntW'(col_nxt) + CntW'(1);
  assign rd_addr      = rd_addr_full[ColW-1:0];

  // Absent pairs stand in as the current best, which leaves the merge unchanged.
  always_comb begin
    c_left    = (col_q != '0) ? make_pair(pix, left_q) : best_q;
    c_upleft  = (row_q != '0 && col_q != '0) ? make_pair(pix, upleft_q) : best_q;
    c_up      = (row_q != '0) ? make_pair(pix, up_q) : best_q;
    c_upright = (row_q != '0 && !last_col) ? make_pair(pix, upright) : best_q;
    m_a       = merge(c_left, c_upleft);
    m_b       = merge(c_up, c_upright);
    m_all     = merge(m_a, m_b);
    best_d    = merge(best_q, m_all);
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      row_mem[col_q] <= pix;
      rd_q           <= row_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q      <= SideBits'(SideReset);
      col_q       <= '0;
      row_q       <= '0;
      left_q      <= '0;
      upleft_q    <= '0;
      up_q        <= '0;
      first_q     <= '0;
      fwd_q       <= 1'b0;
      fwd_pix_q   <= '0;
      best_q      <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (accept && frame_end && !cfg_we_i) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        side_q   <= cfg_wdata_i;
        col_q    <= '0;
        row_q    <= '0;
        left_q   <= '0;
        upleft_q <= '0;
        best_q   <= '0;
      end else if (accept) begin
        left_q    <= frame_end ? '0 : pix;
        upleft_q  <= frame_end ? '0 : up_q;
        // at a row wrap the pixel above is the first one of the row just finished
        up_q      <= last_col ? ((col_q == '0) ? pix : first_q) : upright;
        first_q   <= (col_q == '0) ? pix : first_q;
        fwd_q     <= (rd_addr_full == CntW'(col_q));
        fwd_pix_q <= pix;
        col_q     <= col_nxt;
        if (frame_end) begin
          row_q  <= '0;
          best_q <= '0;
          out_q  <= best_d;
        end else begin
          row_q  <= last_col ? row_q + ColW'(1) : row_q;
          best_q <= best_d;
        end
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutW'({out_q.diff, out_q.low, out_q.high});

endmodule
